>>> hw/rtl/srtdiv_pkg.sv
package srtdiv_pkg;

  // Field widths of the item channels
  localparam int unsigned DIVIDEND_W = 64;
  localparam int unsigned DIVISOR_W  = 32;
  localparam int unsigned QUOT_W     = 32;
  localparam int unsigned REM_W      = 32;
  localparam int unsigned TALLY_W    = 6;

  // Default operand width
  localparam int unsigned WIDTH_DEF  = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_OUT
  } srtdiv_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic fix;
    logic emit;
  } srtdiv_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_err;
  } srtdiv_status_t;

endpackage

>>> hw/rtl/srtdiv_if.sv
interface srtdiv_in_if import srtdiv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVISOR_W-1:0]  divisor;

  modport source(output valid, dividend, divisor, input ready);
  modport sink(input valid, dividend, divisor, output ready);
endinterface

interface srtdiv_out_if import srtdiv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [QUOT_W-1:0]  quotient;
  logic [REM_W-1:0]   remainder;
  logic [TALLY_W-1:0] add_count;
  logic               error;

  modport source(output valid, quotient, remainder, add_count, error, input ready);
  modport sink(input valid, quotient, remainder, add_count, error, output ready);
endinterface

>>> hw/rtl/srt_radix2_divider.sv
// Sequence: the accept edge loads the operands, then one SRT digit per cycle (add,
//   subtract or pass), one correction step and one output step that waits until the
//   output register is free; a rejected operand skips the digit and correction steps
//   and goes straight to the output step.
// The next item is taken only once the output step is done, but it is taken while
//   a result still waits in the output register.
// Reset: rst_ni asynchronous, active low; clears control to idle, no result valid.
module srt_radix2_divider import srtdiv_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  srtdiv_in_if.sink    in_i,
  srtdiv_out_if.source out_o
);

  srtdiv_cmd_t    cmd;
  srtdiv_status_t status;

  srtdiv_ctrl #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srtdiv_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dividend_i  (in_i.dividend),
    .divisor_i   (in_i.divisor),
    .cmd_i       (cmd),
    .status_o    (status),
    .quotient_o  (out_o.quotient),
    .remainder_o (out_o.remainder),
    .add_count_o (out_o.add_count),
    .error_o     (out_o.error)
  );

endmodule

>>> hw/rtl/srtdiv_ctrl.sv
module srtdiv_ctrl import srtdiv_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  srtdiv_status_t status_i,
  output srtdiv_cmd_t    cmd_o
);

  localparam int unsigned CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

  srtdiv_state_e    state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.op_err ? ST_OUT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q == LAST_STEP) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_RUN:  cmd_o.step = 1'b1;
      ST_FIX:  cmd_o.fix  = 1'b1;
      ST_OUT:  cmd_o.emit = slot_free;
      default: cmd_o = '0;
    endcase
  end

  // Step count and result valid
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.load) begin
      cnt_d = '0;
    end else if (cmd_o.step) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // Last digit step is followed by the correction step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == LAST_STEP) |=> state_q == ST_FIX)
    else $error("srtdiv_ctrl: correction did not follow last step");

  // A new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !(out_valid_q && !out_ready_i))
    else $error("srtdiv_ctrl: result overwritten");

  // Only one command at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.step, cmd_o.fix, cmd_o.emit}))
    else $error("srtdiv_ctrl: overlapping commands");
`endif

endmodule

>>> hw/rtl/srtdiv_dp.sv
module srtdiv_dp import srtdiv_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  input  srtdiv_cmd_t           cmd_i,
  output srtdiv_status_t        status_o,
  output logic [QUOT_W-1:0]     quotient_o,
  output logic [REM_W-1:0]      remainder_o,
  output logic [TALLY_W-1:0]    add_count_o,
  output logic                  error_o
);

  // Partial remainder spans (-2d, 2d) after the shift
  localparam int unsigned RW = WIDTH + 2;
  localparam logic signed [RW-1:0] HALF  = RW'(1) << (WIDTH - 1);
  localparam logic signed [RW-1:0] NHALF = -HALF;

  logic signed [RW-1:0] rem_q, rem_d;
  logic [WIDTH-1:0]     low_q, low_d;
  logic [WIDTH-1:0]     qp_q, qp_d;
  logic [WIDTH-1:0]     qm_q, qm_d;
  logic [WIDTH-1:0]     dv_q, dv_d;
  logic [TALLY_W-1:0]   tally_q, tally_d;
  logic                 err_q, err_d;

  logic [WIDTH-1:0]     hi_in;
  logic [WIDTH-1:0]     dv_in;
  logic signed [RW-1:0] shifted;
  logic signed [RW-1:0] dv_ext;
  logic                 neg;

  assign hi_in  = dividend_i[2*WIDTH-1 -: WIDTH];
  assign dv_in  = divisor_i[WIDTH-1:0];
  assign status_o.op_err = !dv_in[WIDTH-1] || (hi_in >= dv_in);

  assign shifted = {rem_q[RW-2:0], low_q[WIDTH-1]};
  assign dv_ext  = RW'(dv_q);
  assign neg     = rem_q[RW-1];

  // Load operands, run one digit, or correct a negative remainder
  always_comb begin
    rem_d   = rem_q;
    low_d   = low_q;
    qp_d    = qp_q;
    qm_d    = qm_q;
    dv_d    = dv_q;
    tally_d = tally_q;
    err_d   = err_q;
    priority if (cmd_i.load) begin
      rem_d   = RW'(hi_in);
      low_d   = dividend_i[WIDTH-1:0];
      qp_d    = '0;
      qm_d    = '0;
      dv_d    = dv_in;
      tally_d = '0;
      err_d   = status_o.op_err;
    end else if (cmd_i.step) begin
      low_d = low_q << 1;
      qp_d  = qp_q << 1;
      qm_d  = qm_q << 1;
      if (shifted >= HALF) begin
        rem_d   = shifted - dv_ext;
        qp_d[0] = 1'b1;
        tally_d = tally_q + TALLY_W'(1);
      end else if (shifted < NHALF) begin
        rem_d   = shifted + dv_ext;
        qm_d[0] = 1'b1;
        tally_d = tally_q + TALLY_W'(1);
      end else begin
        rem_d = shifted;
      end
    end else if (cmd_i.fix) begin
      qp_d    = qp_q - qm_q - WIDTH'(neg);
      rem_d   = neg ? rem_q + dv_ext : rem_q;
      tally_d = tally_q + TALLY_W'(neg);
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    qp_q  <= qp_d;
    qm_q  <= qm_d;
    dv_q  <= dv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q <= '0;
      err_q   <= 1'b0;
    end else begin
      tally_q <= tally_d;
      err_q   <= err_d;
    end
  end

  // Capture the result; zero quotient, remainder and add count on a rejected operand
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      quotient_o  <= err_q ? '0 : QUOT_W'(qp_q);
      remainder_o <= err_q ? '0 : REM_W'(rem_q[WIDTH-1:0]);
      add_count_o <= err_q ? '0 : tally_q;
      error_o     <= err_q;
    end
  end

`ifndef SYNTHESIS
  // Remainder magnitude stays within the divisor after each digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (rem_q < dv_ext) && (rem_q >= -dv_ext))
    else $error("srtdiv_dp: partial remainder out of range");

  // Corrected remainder is in 0 .. divisor-1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !err_q) |-> (!rem_q[RW-1] && (rem_q < dv_ext)))
    else $error("srtdiv_dp: final remainder not reduced");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench import srtdiv_pkg::*; ();

  localparam int unsigned OP_W        = WIDTH_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned RANDOM_ITEMS = 640;

  typedef struct packed {
    logic [QUOT_W-1:0]  quotient;
    logic [REM_W-1:0]   remainder;
    logic [TALLY_W-1:0] add_count;
    logic               error;
  } div_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // Sender and receiver pacing controls
  bit idle_enable  = 1'b1;
  bit hold_request = 1'b0;

  div_result_t expected_divisions[$];
  int unsigned mismatch_count = 0;

  srtdiv_in_if  div_in();
  srtdiv_out_if div_out();

  srt_radix2_divider u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (div_in),
    .out_o  (div_out)
  );

  always #4 clk = ~clk;

  // Radix-2 SRT division: digits +1/0/-1 per step, then sign fix-up
  function automatic div_result_t srt_divide(input logic [DIVIDEND_W-1:0] dvd,
                                             input logic [DIVISOR_W-1:0] dvs);
    div_result_t        res;
    longint             rem;
    longint             shifted;
    longint             half;
    longint             dv;
    logic [OP_W-1:0]    plus_digits;
    logic [OP_W-1:0]    minus_digits;
    logic [OP_W-1:0]    quot;
    logic [TALLY_W-1:0] tally;
    res = '0;
    if (!dvs[OP_W-1] || dvd[2*OP_W-1:OP_W] >= dvs[OP_W-1:0]) begin
      res.error = 1'b1;
      return res;
    end
    half         = longint'(1) << (OP_W - 1);
    dv           = longint'(dvs[OP_W-1:0]);
    rem          = longint'(dvd[2*OP_W-1:OP_W]);
    plus_digits  = '0;
    minus_digits = '0;
    tally        = '0;
    for (int i = OP_W - 1; i >= 0; i--) begin
      shifted = rem * 2;
      if (dvd[i]) shifted = shifted + 1;
      plus_digits  = plus_digits << 1;
      minus_digits = minus_digits << 1;
      if (shifted >= half) begin
        rem            = shifted - dv;
        plus_digits[0] = 1'b1;
        tally          = tally + 1'b1;
      end else if (shifted < -half) begin
        rem             = shifted + dv;
        minus_digits[0] = 1'b1;
        tally           = tally + 1'b1;
      end else begin
        rem = shifted;
      end
    end
    quot = plus_digits - minus_digits;
    // Correct a negative final remainder
    if (rem < 0) begin
      rem   = rem + dv;
      quot  = quot - 1'b1;
      tally = tally + 1'b1;
    end
    res.quotient  = quot;
    res.remainder = rem[OP_W-1:0];
    res.add_count = tally;
    return res;
  endfunction

  // Mostly zero, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 88) return $urandom_range(1, 3);
    else if (roll < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Mostly legal operands with random content, some rejected ones
  task automatic random_operands(output logic [DIVIDEND_W-1:0] dvd,
                                 output logic [DIVISOR_W-1:0] dvs);
    int unsigned roll;
    logic [OP_W-1:0] upper;
    logic [OP_W-1:0] lower;
    roll  = $urandom_range(0, 99);
    dvs   = $urandom() | 32'h8000_0000;
    lower = $urandom();
    if (roll < 60) begin
      upper = $urandom_range(0, dvs - 1);
    end else if (roll < 70) begin
      upper = dvs - 1 - $urandom_range(0, 15);
    end else if (roll < 78) begin
      upper = $urandom_range(0, 255);
    end else if (roll < 88) begin
      // exact multiple, remainder zero
      dvd = {32'd0, dvs} * {32'd0, 32'($urandom())};
      return;
    end else if (roll < 94) begin
      dvs   = $urandom() & 32'h7FFF_FFFF;
      upper = $urandom();
    end else begin
      upper = $urandom_range(dvs, 32'hFFFF_FFFF);
    end
    dvd = {upper, lower};
  endtask

  // Offer one item and record its expected result once accepted
  task automatic offer_division(input logic [DIVIDEND_W-1:0] dvd,
                                input logic [DIVISOR_W-1:0] dvs);
    int unsigned gap;
    gap = idle_enable ? pick_gap() : 0;
    if (gap > 0) begin
      div_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    div_in.valid    <= 1'b1;
    div_in.dividend <= dvd;
    div_in.divisor  <= dvs;
    do @(posedge clk); while (!div_in.ready);
    expected_divisions.push_back(srt_divide(dvd, dvs));
  endtask

  task automatic test_directed_cases();
    offer_division(64'h0, 32'h8000_0000);
    offer_division(64'h1, 32'h8000_0000);
    offer_division({32'hFFFF_FFFE, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
    offer_division({32'h7FFF_FFFF, 32'hFFFF_FFFF}, 32'h8000_0000);
    offer_division({32'h0, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
    // shifted remainder lands exactly on plus one half
    offer_division({32'h4000_0000, 32'h0}, 32'h8000_0001);
    // shifted remainder lands exactly on minus one half
    offer_division({32'h8000_0000, 32'h0}, 32'hC000_0000);
    offer_division({32'h8000_0000, 32'h0000_0001}, 32'hC000_0000);
    // exact quotients with remainder zero, then ones with a nonzero remainder
    offer_division(64'hFFFF_FFFE_0000_0001, 32'hFFFF_FFFF);
    offer_division(64'h4000_0000_0000_0000, 32'h8000_0000);
    offer_division(64'h9000_0000_0000_0000 / 64'h2, 32'hC000_0000);
    offer_division({32'h2AAA_AAAA, 32'hAAAA_AAAA}, 32'hAAAA_AAAB);
    offer_division({32'h5555_5555, 32'h5555_5555}, 32'hD555_5555);
    offer_division({32'hFFFF_FFFE, 32'h0}, 32'hFFFF_FFFF);
  endtask

  task automatic test_operand_errors();
    offer_division(64'h0, 32'h0);
    offer_division(64'h1234_5678, 32'h1);
    offer_division({32'h0, 32'hFFFF_FFFF}, 32'h7FFF_FFFF);
    offer_division({32'h8000_0000, 32'h0}, 32'h8000_0000);
    offer_division({32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'hFFFF_FFFF);
    offer_division({32'hFFFF_FFFF, 32'h0}, 32'h8000_0000);
    offer_division({32'hFFFF_FFFF, 32'hFFFF_FFFF}, 32'h0);
    // legal item right after a rejected one
    offer_division({32'h1234_5678, 32'h9ABC_DEF0}, 32'hFEDC_BA98);
  endtask

  task automatic test_back_to_back();
    logic [DIVIDEND_W-1:0] dvd;
    logic [DIVISOR_W-1:0]  dvs;
    idle_enable = 1'b0;
    repeat (30) begin
      random_operands(dvd, dvs);
      offer_division(dvd, dvs);
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_output_backpressure();
    logic [DIVIDEND_W-1:0] dvd;
    logic [DIVISOR_W-1:0]  dvs;
    hold_request = 1'b1;
    idle_enable  = 1'b0;
    repeat (12) begin
      random_operands(dvd, dvs);
      offer_division(dvd, dvs);
    end
    idle_enable = 1'b1;
  endtask

  task automatic test_random_divisions();
    logic [DIVIDEND_W-1:0] dvd;
    logic [DIVISOR_W-1:0]  dvs;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_operands(dvd, dvs);
      offer_division(dvd, dvs);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    rst_n           = 1'b0;
    div_in.valid    = 1'b0;
    div_in.dividend = '0;
    div_in.divisor  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_operand_errors();
    test_back_to_back();
    test_output_backpressure();
    test_random_divisions();
    div_in.valid <= 1'b0;
    while (expected_divisions.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_divisions.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver: random stalls plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_taken;
    stall_left    = 0;
    hold_taken    = 1'b0;
    div_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_taken) begin
        stall_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (stall_left > 0) begin
        div_out.ready <= 1'b0;
        stall_left--;
      end else begin
        div_out.ready <= 1'b1;
        if (idle_enable && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    div_result_t got;
    div_result_t want;
    if (rst_n && div_out.valid && div_out.ready) begin
      got = '{div_out.quotient, div_out.remainder, div_out.add_count, div_out.error};
      if (expected_divisions.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result q=%h r=%h n=%0d err=%b", $realtime,
                   got.quotient, got.remainder, got.add_count, got.error);
        mismatch_count++;
      end else begin
        want = expected_divisions.pop_front();
        if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
            got.add_count !== want.add_count || got.error !== want.error) begin
          if (mismatch_count < 10)
            $display("%0t: mismatch exp q=%h r=%h n=%0d err=%b got q=%h r=%h n=%0d err=%b",
                     $realtime, want.quotient, want.remainder, want.add_count, want.error,
                     got.quotient, got.remainder, got.add_count, got.error);
          mismatch_count++;
        end
      end
    end
  end

  // End the run when no item moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((div_in.valid && div_in.ready) || (div_out.valid && div_out.ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

endmodule
